@@ src/ccm_pkg.sv @@
// ----------------------------------------------------------------------------
// ccm_pkg
// Shared constants and types for the color correction matrix pipeline.
// ----------------------------------------------------------------------------
package ccm_pkg;

	localparam int FRACTION_BITS = 10;

	localparam int PIX_W   = 14;
	localparam int COEF_W  = 16;
	localparam int ROW_W   = 64;
	localparam int DEPTH_W = 4;
	localparam int IDX_W   = 2;

	// Unsigned sample times signed coefficient, and the exact sum of three
	// products plus the offset.
	localparam int PROD_W = PIX_W + 1 + COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SHR_W  = SUM_W - FRACTION_BITS;

	localparam logic [DEPTH_W-1:0] PIX_MIN_BITS = 4'd8;
	localparam logic [DEPTH_W-1:0] PIX_MAX_BITS = 4'd14;

	localparam logic [IDX_W-1:0] REG_ROW_RED   = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROW_GREEN = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROW_BLUE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_PIX_BITS  = 2'd3;

	localparam logic [ROW_W-1:0]   ROW_RED_RST   = 64'd1024;
	localparam logic [ROW_W-1:0]   ROW_GREEN_RST = 64'd1024 << 16;
	localparam logic [ROW_W-1:0]   ROW_BLUE_RST  = 64'd1024 << 32;
	localparam logic [DEPTH_W-1:0] PIX_BITS_RST  = 4'd10;

	// Per-stage load enables shared by the three channel datapaths.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} ccm_pipe_ctrl_t;

endpackage

@@ src/ccm_channel.sv @@
// ----------------------------------------------------------------------------
// ccm_channel
// Datapath of one output channel: multiply, sum with offset, clamp and scale.
// ----------------------------------------------------------------------------
module ccm_channel import ccm_pkg::*; (
	input  logic                  clk,
	input  ccm_pipe_ctrl_t        ctrl,
	input  logic [ROW_W-1:0]      row,
	input  logic [PIX_W-1:0]      red,
	input  logic [PIX_W-1:0]      green,
	input  logic [PIX_W-1:0]      blue,
	input  logic [PIX_W-1:0]      max_val,
	output logic [PIX_W-1:0]      result
);

	logic signed [COEF_W-1:0] coef_r, coef_g, coef_b, offset;
	logic signed [PROD_W-1:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic signed [SUM_W-1:0]  sum_s2;
	logic [SHR_W-1:0]         shifted;
	logic [PIX_W-1:0]         result_s3;

	assign coef_r = row[15:0];
	assign coef_g = row[31:16];
	assign coef_b = row[47:32];
	assign offset = row[63:48];

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			prod_r_s1 <= PROD_W'($signed({1'b0, red}))   * PROD_W'(coef_r);
			prod_g_s1 <= PROD_W'($signed({1'b0, green})) * PROD_W'(coef_g);
			prod_b_s1 <= PROD_W'($signed({1'b0, blue}))  * PROD_W'(coef_b);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			sum_s2 <= SUM_W'(prod_r_s1) + SUM_W'(prod_g_s1) + SUM_W'(prod_b_s1)
				+ SUM_W'(offset);
		end
	end

	assign shifted = sum_s2[SUM_W-1:FRACTION_BITS];

	// A negative sum clamps to zero before the scale-down.
	always_ff @(posedge clk) begin
		if (ctrl.en3) begin
			if (sum_s2[SUM_W-1]) begin
				result_s3 <= '0;
			end else if (shifted > {{(SHR_W-PIX_W){1'b0}}, max_val}) begin
				result_s3 <= max_val;
			end else begin
				result_s3 <= shifted[PIX_W-1:0];
			end
		end
	end

	assign result = result_s3;

endmodule

@@ src/color_correction_matrix.sv @@
// ----------------------------------------------------------------------------
// color_correction_matrix
// 3x3 color correction with per-channel offset, clamped to the pixel depth.
// Throughput is one pixel per cycle while out_stall is low; the three
// register stages are multiply, sum with offset, and clamp/scale, and
// stalls backpressure stage by stage so that empty stages keep filling.
// Reset clears the stage valid bits and loads the identity matrix, zero
// offsets and a 10-bit pixel depth.
// ----------------------------------------------------------------------------
module color_correction_matrix import ccm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [ROW_W-1:0]   wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIX_W-1:0]   red_in,
	input  logic [PIX_W-1:0]   green_in,
	input  logic [PIX_W-1:0]   blue_in,
	input  logic               frame_end_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [PIX_W-1:0]   red_out,
	output logic [PIX_W-1:0]   green_out,
	output logic [PIX_W-1:0]   blue_out,
	output logic               frame_end_out
);

	logic [ROW_W-1:0]   row_red_q, row_green_q, row_blue_q;
	logic [DEPTH_W-1:0] pix_bits_q;
	logic [DEPTH_W-1:0] depth;
	logic [PIX_W-1:0]   max_val;

	logic           valid_s1, valid_s2, valid_s3;
	logic           fe_s1, fe_s2, fe_s3;
	ccm_pipe_ctrl_t ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_red_q   <= ROW_RED_RST;
			row_green_q <= ROW_GREEN_RST;
			row_blue_q  <= ROW_BLUE_RST;
			pix_bits_q  <= PIX_BITS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW_RED:   row_red_q   <= wr_data;
				REG_ROW_GREEN: row_green_q <= wr_data;
				REG_ROW_BLUE:  row_blue_q  <= wr_data;
				REG_PIX_BITS:  pix_bits_q  <= wr_data[DEPTH_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		priority if (pix_bits_q < PIX_MIN_BITS) begin
			depth = PIX_MIN_BITS;
		end else if (pix_bits_q > PIX_MAX_BITS) begin
			depth = PIX_MAX_BITS;
		end else begin
			depth = pix_bits_q;
		end
	end

	assign max_val = PIX_W'(({{PIX_W{1'b0}}, 1'b1} << depth) - {{PIX_W{1'b0}}, 1'b1});

	// A stage loads when it is empty or its contents move on this cycle.
	assign ctrl.en3 = !valid_s3 || !out_stall;
	assign ctrl.en2 = !valid_s2 || ctrl.en3;
	assign ctrl.en1 = !valid_s1 || ctrl.en2;
	assign in_stall = !ctrl.en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ctrl.en1) begin
				valid_s1 <= in_valid;
			end
			if (ctrl.en2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			fe_s1 <= frame_end_in;
		end
		if (ctrl.en2) begin
			fe_s2 <= fe_s1;
		end
		if (ctrl.en3) begin
			fe_s3 <= fe_s2;
		end
	end

	ccm_channel u_red (
		.clk     (clk),
		.ctrl    (ctrl),
		.row     (row_red_q),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.max_val (max_val),
		.result  (red_out)
	);

	ccm_channel u_green (
		.clk     (clk),
		.ctrl    (ctrl),
		.row     (row_green_q),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.max_val (max_val),
		.result  (green_out)
	);

	ccm_channel u_blue (
		.clk     (clk),
		.ctrl    (ctrl),
		.row     (row_blue_q),
		.red     (red_in),
		.green   (green_in),
		.blue    (blue_in),
		.max_val (max_val),
		.result  (blue_out)
	);

	assign out_valid     = valid_s3;
	assign frame_end_out = fe_s3;

endmodule

@@ verif/tb_color_correction_matrix.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_correction_matrix
// Streams pixels through the color correction matrix under several matrix,
// offset and pixel depth settings. A local model predicts every corrected
// pixel at input acceptance, and the monitor compares each output
// transaction field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_color_correction_matrix;
	import ccm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_PIXELS  = 305;
	localparam int PIX_FULL      = (1 << PIX_W) - 1;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             frame_end;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               wr_en = 1'b0;
	logic [IDX_W-1:0]   wr_index = REG_ROW_RED;
	logic [ROW_W-1:0]   wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [PIX_W-1:0]   red_in = '0;
	logic [PIX_W-1:0]   green_in = '0;
	logic [PIX_W-1:0]   blue_in = '0;
	logic               frame_end_in = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [PIX_W-1:0]   red_out;
	logic [PIX_W-1:0]   green_out;
	logic [PIX_W-1:0]   blue_out;
	logic               frame_end_out;

	// Local copy of the block's registers.
	logic [ROW_W-1:0]   red_row = ROW_RED_RST;
	logic [ROW_W-1:0]   green_row = ROW_GREEN_RST;
	logic [ROW_W-1:0]   blue_row = ROW_BLUE_RST;
	logic [DEPTH_W-1:0] depth_cfg = PIX_BITS_RST;

	pixel_t source_pixels[$];
	pixel_t corrected_pixels[$];
	pixel_t sent_pixel;
	pixel_t predicted;
	int     pixels_in_flight = 0;
	int     error_count = 0;
	int     result_count = 0;
	int     cycle_count = 0;
	int     send_idle_pct = 20;
	int     stall_pct = 75;

	color_correction_matrix i_dut (.*);

	always #10 clk = ~clk;

	function automatic longint pixel_max(logic [DEPTH_W-1:0] depth);
		logic [DEPTH_W-1:0] eff;
		eff = depth;
		if (eff < PIX_MIN_BITS) eff = PIX_MIN_BITS;
		if (eff > PIX_MAX_BITS) eff = PIX_MAX_BITS;
		return (longint'(1) << eff) - 1;
	endfunction

	// One output channel: exact dot product plus offset, floor at zero,
	// drop the fraction, then saturate at the pixel maximum.
	function automatic logic [PIX_W-1:0] row_dot(logic [ROW_W-1:0] row, pixel_t px,
			longint top);
		longint acc;
		acc = longint'(px.red) * longint'($signed(row[15:0]))
			+ longint'(px.green) * longint'($signed(row[31:16]))
			+ longint'(px.blue) * longint'($signed(row[47:32]))
			+ longint'($signed(row[63:48]));
		if (acc < 0) acc = 0;
		acc = acc >> FRACTION_BITS;
		if (acc > top) acc = top;
		return acc[PIX_W-1:0];
	endfunction

	function automatic pixel_t correct_pixel(pixel_t px);
		pixel_t res;
		longint top;
		top = pixel_max(depth_cfg);
		res.red       = row_dot(red_row, px, top);
		res.green     = row_dot(green_row, px, top);
		res.blue      = row_dot(blue_row, px, top);
		res.frame_end = px.frame_end;
		return res;
	endfunction

	function automatic logic [ROW_W-1:0] make_row(logic [15:0] cr, logic [15:0] cg,
			logic [15:0] cb, logic [15:0] off);
		return {off, cb, cg, cr};
	endfunction

	function automatic logic [ROW_W-1:0] random_row();
		logic [ROW_W-1:0] row;
		int style;
		int val;
		style = $urandom_range(0, 5);
		row = {$urandom, $urandom};
		if (style != 0) begin
			for (int f = 0; f < 4; f++) begin
				if (style == 1) begin
					case ($urandom_range(0, 3))
						0: val = 32'h8000;
						1: val = 32'h7FFF;
						2: val = 0;
						default: val = -1;
					endcase
				end else if (f == 3) begin
					val = $urandom_range(0, 8192) - 4096;
				end else begin
					// Mostly gains between -1.0 and 2.0.
					val = $urandom_range(0, 3072) - 1024;
				end
				row[16*f +: 16] = val[15:0];
			end
		end
		return row;
	endfunction

	// The model copy is updated as the write is driven; writes only happen
	// while no pixel is in flight.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			REG_ROW_RED:   red_row = data;
			REG_ROW_GREEN: green_row = data;
			REG_ROW_BLUE:  blue_row = data;
			REG_PIX_BITS:  depth_cfg = data[DEPTH_W-1:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic queue_pixel(int r, int g, int b, bit fe);
		pixel_t px;
		px.red       = r[PIX_W-1:0];
		px.green     = g[PIX_W-1:0];
		px.blue      = b[PIX_W-1:0];
		px.frame_end = fe;
		source_pixels.push_back(px);
		pixels_in_flight++;
	endtask

	task automatic wait_drained();
		while (pixels_in_flight != 0) @(posedge clk);
	endtask

	// Driver: a stalled transaction holds its payload; otherwise the next
	// pixel is presented unless the sender idles this cycle.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				corrected_pixels.push_back(correct_pixel(sent_pixel));
			if (!in_valid || !in_stall) begin
				if (source_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					sent_pixel = source_pixels.pop_front();
					red_in       <= sent_pixel.red;
					green_in     <= sent_pixel.green;
					blue_in      <= sent_pixel.blue;
					frame_end_in <= sent_pixel.frame_end;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted output transaction and drives the stall.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (corrected_pixels.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("result %0d: output pixel with none predicted (r=%0d g=%0d b=%0d fe=%0b)",
						result_count, red_out, green_out, blue_out, frame_end_out);
			end else begin
				predicted = corrected_pixels.pop_front();
				pixels_in_flight--;
				if (red_out !== predicted.red || green_out !== predicted.green ||
						blue_out !== predicted.blue || frame_end_out !== predicted.frame_end) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("result %0d: expected r=%0d g=%0d b=%0d fe=%0b, got r=%0d g=%0d b=%0d fe=%0b",
							result_count, predicted.red, predicted.green, predicted.blue,
							predicted.frame_end, red_out, green_out, blue_out, frame_end_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [ROW_W-1:0] depth_word;
		int depth_val;
		int lim;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: identity matrix, zero offsets, 10-bit pixels.
		queue_pixel(0, 0, 0, 1'b0);
		queue_pixel(PIX_FULL, PIX_FULL, PIX_FULL, 1'b1);
		queue_pixel(1023, 512, 1, 1'b0);
		queue_pixel(1024, 0, PIX_FULL, 1'b1);
		queue_pixel(14'h2AAA, 14'h1555, 14'h2AAA, 1'b0);
		wait_drained();

		// Most negative row clamps to zero, most positive row saturates, and a
		// depth below the legal range acts as 8 bits. Upper data bits of the
		// depth write are ignored.
		write_reg(REG_ROW_RED, make_row(16'h8000, 16'h8000, 16'h8000, 16'h8000));
		write_reg(REG_ROW_GREEN, make_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		write_reg(REG_ROW_BLUE, make_row(16'h0400, 16'hFE00, 16'h0100, 16'hFED4));
		write_reg(REG_PIX_BITS, 64'hFFFF_FFFF_FFFF_FFF3);
		queue_pixel(0, 0, 0, 1'b0);
		queue_pixel(PIX_FULL, PIX_FULL, PIX_FULL, 1'b1);
		queue_pixel(200, 100, 50, 1'b0);
		queue_pixel(255, 255, 255, 1'b1);
		wait_drained();

		// A depth above the legal range acts as 14 bits.
		write_reg(REG_ROW_RED, make_row(16'h7FFF, 16'h0000, 16'h0000, 16'h0000));
		write_reg(REG_ROW_GREEN, make_row(16'h0000, 16'h8000, 16'h7FFF, 16'h0000));
		write_reg(REG_ROW_BLUE, make_row(16'h0200, 16'h0200, 16'h0200, 16'h01FF));
		write_reg(REG_PIX_BITS, 64'd15);
		queue_pixel(PIX_FULL, 0, 0, 1'b0);
		queue_pixel(PIX_FULL, PIX_FULL, PIX_FULL, 1'b1);
		queue_pixel(1, 1, 1, 1'b0);
		queue_pixel(0, PIX_FULL, 0, 1'b0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < RANDOM_PHASES / 3) begin
				send_idle_pct = 20;
				stall_pct     = 75;
			end else if (ph < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 75;
				stall_pct     = 20;
			end else begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			wait_drained();
			write_reg(REG_ROW_RED, random_row());
			write_reg(REG_ROW_GREEN, random_row());
			write_reg(REG_ROW_BLUE, random_row());
			depth_val = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
				: $urandom_range(PIX_MIN_BITS, PIX_MAX_BITS);
			depth_word = {$urandom, $urandom};
			depth_word[DEPTH_W-1:0] = depth_val[DEPTH_W-1:0];
			write_reg(REG_PIX_BITS, depth_word);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// Most samples stay within the pixel depth; some use all 14 bits.
				lim = ($urandom_range(0, 3) == 0) ? PIX_FULL : int'(pixel_max(depth_cfg));
				queue_pixel($urandom_range(0, lim), $urandom_range(0, lim),
					$urandom_range(0, lim), $urandom_range(0, 15) == 0);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
